// ===== hdl/dffb_pkg.sv =====
// ----------------------------------------------------------------------------
// dffb_pkg
// Shared types, constants and the CRC-16 byte update for the frame builder.
// ----------------------------------------------------------------------------
package dffb_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [7:0]  SYNC_CRC  = 8'hA0;
    localparam logic [7:0]  SYNC_CRLF = 8'hA3;
    localparam logic [7:0]  END_CR    = 8'h0D;
    localparam logic [7:0]  END_LF    = 8'h0A;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    localparam logic [15:0] LEN_ADD_CRC  = 16'd7;
    localparam logic [15:0] LEN_ADD_CRLF = 16'd8;
    localparam logic [15:0] PLEN_MAX_CRC = 16'd248;

    localparam logic [3:0] HDR_CNT_CRC  = 4'd7;
    localparam logic [3:0] HDR_CNT_CRLF = 4'd9;

    typedef struct packed {
        logic        opcode;
        logic        use_crlf_format;
        logic [7:0]  source_id;
        logic [7:0]  target_id;
        logic [7:0]  frame_kind;
        logic [7:0]  main_command;
        logic [7:0]  sub_command;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } held_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== hdl/dffb_if.sv =====
// ----------------------------------------------------------------------------
// dffb request and result channels
// Valid/ready channels carrying one request or one frame byte.
// ----------------------------------------------------------------------------
interface dffb_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic        use_crlf_format;
    logic [7:0]  source_id;
    logic [7:0]  target_id;
    logic [7:0]  frame_kind;
    logic [7:0]  main_command;
    logic [7:0]  sub_command;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;

    modport source (output valid, opcode, use_crlf_format, source_id, target_id,
                    frame_kind, main_command, sub_command, payload_length,
                    data_byte, input ready);
    modport sink   (input valid, opcode, use_crlf_format, source_id, target_id,
                    frame_kind, main_command, sub_command, payload_length,
                    data_byte, output ready);
endinterface

interface dffb_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       length_overflow;

    modport source (output valid, out_byte, frame_end, length_overflow,
                    input ready);
    modport sink   (input valid, out_byte, frame_end, length_overflow,
                    output ready);
endinterface

// ===== hdl/dffb_in_stage.sv =====
// ----------------------------------------------------------------------------
// dffb_in_stage
// Input register: holds one request until the sequencer has consumed it.
// ----------------------------------------------------------------------------
module dffb_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    dffb_req_if.sink            req,
    input  logic                take,
    output dffb_pkg::held_t     held
);
    import dffb_pkg::*;

    logic  hold_v_reg;
    item_t item_reg;
    logic  load;

    assign req.ready = !hold_v_reg || take;
    assign load      = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_v_reg <= 1'b0;
        else if (load)
            hold_v_reg <= 1'b1;
        else if (take)
            hold_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.opcode          <= req.opcode;
            item_reg.use_crlf_format <= req.use_crlf_format;
            item_reg.source_id       <= req.source_id;
            item_reg.target_id       <= req.target_id;
            item_reg.frame_kind      <= req.frame_kind;
            item_reg.main_command    <= req.main_command;
            item_reg.sub_command     <= req.sub_command;
            item_reg.payload_length  <= req.payload_length;
            item_reg.data_byte       <= req.data_byte;
        end
    end

    assign held.valid = hold_v_reg;
    assign held.item  = item_reg;

endmodule

// ===== hdl/dffb_seq.sv =====
// ----------------------------------------------------------------------------
// dffb_seq
// Byte sequencer: frame state, CRC update and the registered result byte.
// ----------------------------------------------------------------------------
module dffb_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  dffb_pkg::held_t     held,
    output logic                take,
    dffb_rsp_if.source          rsp
);
    import dffb_pkg::*;

    logic        frame_open_reg;
    logic        open_format_reg;
    logic [15:0] remaining_reg;
    logic [15:0] crc_reg;
    logic        ovf_reg;
    logic [3:0]  idx_reg;
    logic        out_v_reg;
    logic [7:0]  out_byte_reg;
    logic        out_end_reg;
    logic        out_ovf_reg;

    item_t       it;
    logic        is_start;
    logic        fmt;
    logic        ignore;
    logic        first;
    logic [3:0]  body_cnt;
    logic        has_trl;
    logic [3:0]  last_idx;
    logic        in_body;
    logic [3:0]  trl_off;
    logic [15:0] crc_in;
    logic [15:0] crc_next;
    logic        start_ovf;
    logic        ovf_cur;
    logic [15:0] len_crc;
    logic [15:0] len_crlf;
    logic [7:0]  hdr_byte;
    logic [7:0]  cur_byte;
    logic        cur_end;
    logic        out_free;
    logic        emit;
    logic        is_last;

    always_comb
    begin
        it        = held.item;
        is_start  = (it.opcode == OP_START);
        fmt       = is_start ? it.use_crlf_format : open_format_reg;
        first     = (idx_reg == 4'd0);
        // only the first byte index of a payload request decides whether it is dropped
        ignore    = !is_start && first && (!frame_open_reg || remaining_reg == 16'd0);
        body_cnt  = is_start ? (fmt ? HDR_CNT_CRLF : HDR_CNT_CRC) : 4'd1;
        has_trl   = is_start ? (it.payload_length == 16'd0)
                             : (remaining_reg == (first ? 16'd1 : 16'd0));
        last_idx  = has_trl ? body_cnt + 4'd1 : body_cnt - 4'd1;
        in_body   = idx_reg < body_cnt;
        trl_off   = idx_reg - body_cnt;
        crc_in    = (is_start && first) ? CRC_INIT : crc_reg;
        len_crc   = it.payload_length + LEN_ADD_CRC;
        len_crlf  = it.payload_length + LEN_ADD_CRLF;
        start_ovf = !it.use_crlf_format && (it.payload_length > PLEN_MAX_CRC);
        ovf_cur   = (is_start && first) ? start_ovf : ovf_reg;

        if (fmt)
        begin
            case (idx_reg)
                4'd0:    hdr_byte = SYNC_CRLF;
                4'd1:    hdr_byte = len_crlf[15:8];
                4'd2:    hdr_byte = len_crlf[7:0];
                4'd3:    hdr_byte = it.source_id;
                4'd4:    hdr_byte = it.target_id;
                4'd5:    hdr_byte = it.frame_kind;
                4'd6:    hdr_byte = it.main_command;
                4'd7:    hdr_byte = it.sub_command;
                default: hdr_byte = 8'h00;
            endcase
        end
        else
        begin
            case (idx_reg)
                4'd0:    hdr_byte = SYNC_CRC;
                4'd1:    hdr_byte = len_crc[7:0];
                4'd2:    hdr_byte = it.source_id;
                4'd3:    hdr_byte = it.target_id;
                4'd4:    hdr_byte = it.frame_kind;
                4'd5:    hdr_byte = it.main_command;
                default: hdr_byte = it.sub_command;
            endcase
        end

        if (in_body)
            cur_byte = is_start ? hdr_byte : it.data_byte;
        else if (fmt)
            cur_byte = trl_off[0] ? END_LF : END_CR;
        else
            cur_byte = trl_off[0] ? crc_reg[15:8] : crc_reg[7:0];

        cur_end  = !in_body && trl_off[0];
        crc_next = crc16_byte(crc_in, cur_byte);

        out_free = !out_v_reg || rsp.ready;
        emit     = held.valid && !ignore && out_free;
        is_last  = (idx_reg == last_idx);
        take     = held.valid && (ignore || (out_free && is_last));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg  <= 1'b0;
            open_format_reg <= 1'b0;
            remaining_reg   <= 16'd0;
            crc_reg         <= CRC_INIT;
            ovf_reg         <= 1'b0;
            idx_reg         <= 4'd0;
            out_v_reg       <= 1'b0;
        end
        else
        begin
            if (emit)
                out_v_reg <= 1'b1;
            else if (rsp.ready)
                out_v_reg <= 1'b0;

            if (emit)
            begin
                idx_reg <= is_last ? 4'd0 : idx_reg + 4'd1;
                if (first && is_start)
                begin
                    frame_open_reg  <= 1'b1;
                    open_format_reg <= it.use_crlf_format;
                    remaining_reg   <= it.payload_length;
                    ovf_reg         <= start_ovf;
                end
                else if (first)
                    remaining_reg <= remaining_reg - 16'd1;

                if (in_body && !fmt)
                    crc_reg <= crc_next;
                else if (is_start && first)
                    crc_reg <= CRC_INIT;

                if (cur_end)
                    frame_open_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_end_reg  <= cur_end;
            out_ovf_reg  <= ovf_cur;
        end
    end

    assign rsp.valid           = out_v_reg;
    assign rsp.out_byte        = out_byte_reg;
    assign rsp.frame_end       = out_end_reg;
    assign rsp.length_overflow = out_ovf_reg;

endmodule

// ===== hdl/dual_format_frame_builder.sv =====
// ----------------------------------------------------------------------------
// dual_format_frame_builder
// Serializes A0/CRC-16 and A3/CRLF frames from start and payload requests.
// The first byte of a request passes through the input register and the output
// byte register. One output byte per cycle while rsp.ready allows; a payload
// request emits 1 byte, 3 when it closes the frame; a start request 7 to 11 bytes.
// Reset (rst_n low): no frame open, CRC at 0xFFFF, both channels empty.
// ----------------------------------------------------------------------------
module dual_format_frame_builder
(
    input  logic        clk,
    input  logic        rst_n,
    dffb_req_if.sink    req,
    dffb_rsp_if.source  rsp
);
    import dffb_pkg::*;

    held_t held;
    logic  take;

    dffb_in_stage u_in_stage
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .take  (take),
        .held  (held)
    );

    dffb_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .held  (held),
        .take  (take),
        .rsp   (rsp)
    );

endmodule
